// ----- sv/lrucache_pkg.sv -----
`default_nettype none
package lrucache_pkg;

	localparam int SETS    = 2;
	localparam int TAG_W   = 28;
	localparam int WORD_W  = 32;
	localparam int RANK_W  = 3;
	localparam int PEN_W   = 10;

	localparam logic [RANK_W-1:0] RANK_MRU = RANK_W'(1);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(7);
	localparam logic [RANK_W-1:0] RANK_INV = RANK_W'(0);

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FILL  = 2'd2
	} cmd_t;

	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [PEN_W-1:0]  pen_t;

endpackage
`default_nettype wire

// ----- sv/lrucache_if.sv -----
`default_nettype none
interface lrucache_req_if;
	logic                 valid;
	logic                 ready;
	lrucache_pkg::cmd_t   command;
	lrucache_pkg::word_t  address;
	lrucache_pkg::word_t  write_data;
	lrucache_pkg::word_t  fill_word_lo;
	lrucache_pkg::word_t  fill_word_hi;

	modport source (output valid, command, address, write_data, fill_word_lo, fill_word_hi,
		input ready);
	modport sink (input valid, command, address, write_data, fill_word_lo, fill_word_hi,
		output ready);
endinterface

interface lrucache_rsp_if;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	lrucache_pkg::word_t  read_data;
	lrucache_pkg::pen_t   stall_cycles;
	logic                 evict_valid;
	lrucache_pkg::word_t  evict_address;
	lrucache_pkg::word_t  evict_word_lo;
	lrucache_pkg::word_t  evict_word_hi;

	modport source (output valid, hit, read_data, stall_cycles, evict_valid, evict_address,
		evict_word_lo, evict_word_hi, input ready);
	modport sink (input valid, hit, read_data, stall_cycles, evict_valid, evict_address,
		evict_word_lo, evict_word_hi, output ready);
endinterface
`default_nettype wire

// ----- sv/lru_set_assoc_writeback_cache.sv -----
// Two-set, WAYS-way write-back data cache with two-word blocks and LRU ranks.
// The req channel takes one access word: a read, a write or a block fill, with
// the byte address (tag 31:4, set 3, word 2) and the write or fill data.
// The rsp channel returns exactly one word per access: hit, read data, the
// miss penalty on a read/write miss and the block a fill evicts from a full set.
// cfg_we/cfg_wdata load the miss penalty; write it only while the cache is idle.
// An accepted word goes into the stage 1 register, then the rsp register:
// the set's data row is read from block memory into stage 1 on acceptance, and
// the tag compare, LRU update and result are worked out between stage 1 and
// the rsp register. Throughput is one access per cycle unless rsp stalls; the
// set's tags and ranks are updated at the end of stage 1, so a following
// access to the same set sees them at once, and the data row is forwarded.
// A stall on rsp holds the rsp register and stage 1, and req.ready drops
// only when both are full. Reset clears the tags, marks every way invalid,
// empties the pipeline and sets the miss penalty to zero; the block data
// itself is not cleared and needs no clearing pass.
`default_nettype none
module lru_set_assoc_writeback_cache #(
	parameter int WAYS = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  lrucache_pkg::pen_t  cfg_wdata,
	lrucache_req_if.sink        req,
	lrucache_rsp_if.source      rsp
);
	import lrucache_pkg::*;

	typedef word_t [WAYS-1:0][1:0] row_t;
	typedef rank_t [WAYS-1:0]      rank_row_t;
	typedef tag_t  [WAYS-1:0]      tag_row_t;

	pen_t      penalty_q;
	rank_row_t rank_q [SETS];
	tag_row_t  tag_q  [SETS];
	row_t      data_mem [SETS];

	logic  valid_s1;
	cmd_t  cmd_s1;
	tag_t  tag_s1;
	logic  set_s1;
	logic  word_s1;
	word_t wdata_s1;
	word_t flo_s1;
	word_t fhi_s1;
	row_t  row_s1;

	logic  out_valid_q;
	logic  hit_q;
	word_t rdata_q;
	pen_t  stall_q;
	logic  ev_valid_q;
	word_t ev_addr_q;
	word_t ev_lo_q;
	word_t ev_hi_q;

	logic  adv;
	logic  accept;

	rank_row_t rank_cur, rank_nxt;
	tag_row_t  tag_cur, tag_nxt;
	row_t      row_nxt;
	logic [WAYS-1:0] match_oh, empty_oh, lru_oh, victim_oh;
	logic  found_m, found_e;
	rank_t best, hit_rank;
	logic  hit_c, ev_valid_c;
	word_t rdata_c, ev_lo_c, ev_hi_c, ev_addr_c;
	pen_t  stall_c;
	tag_t  ev_tag;

	assign adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;
	assign req.ready = !valid_s1 || adv;

	always_comb begin
		rank_cur = rank_q[set_s1];
		tag_cur  = tag_q[set_s1];
		match_oh = '0;
		empty_oh = '0;
		lru_oh   = '0;
		found_m  = 1'b0;
		found_e  = 1'b0;
		best     = RANK_INV;
		hit_rank = RANK_INV;
		for (int w = 0; w < WAYS; w++) begin
			if (!found_m && rank_cur[w] != RANK_INV && tag_cur[w] == tag_s1) begin
				match_oh[w] = 1'b1;
				found_m     = 1'b1;
				hit_rank    = rank_cur[w];
			end
			if (!found_e && rank_cur[w] == RANK_INV) begin
				empty_oh[w] = 1'b1;
				found_e     = 1'b1;
			end
			// Strict compare keeps the first way among equal highest ranks.
			if (rank_cur[w] > best) begin
				best   = rank_cur[w];
				lru_oh = '0;
				lru_oh[w] = 1'b1;
			end
		end
		victim_oh = found_m ? match_oh : (found_e ? empty_oh : lru_oh);

		ev_tag  = '0;
		ev_lo_c = '0;
		ev_hi_c = '0;
		rdata_c = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (victim_oh[w]) begin
				ev_tag  = tag_cur[w];
				ev_lo_c = row_s1[w][0];
				ev_hi_c = row_s1[w][1];
			end
			if (match_oh[w]) begin
				rdata_c = row_s1[w][word_s1];
			end
		end

		rank_nxt   = rank_cur;
		tag_nxt    = tag_cur;
		row_nxt    = row_s1;
		hit_c      = 1'b0;
		stall_c    = '0;
		ev_valid_c = 1'b0;
		ev_addr_c  = '0;

		case (cmd_s1)
			CMD_READ, CMD_WRITE: begin
				if (found_m) begin
					hit_c = 1'b1;
					for (int w = 0; w < WAYS; w++) begin
						if (match_oh[w]) begin
							rank_nxt[w] = RANK_MRU;
							if (cmd_s1 == CMD_WRITE) begin
								row_nxt[w][word_s1] = wdata_s1;
							end
						end else if (rank_cur[w] != RANK_INV && rank_cur[w] < hit_rank) begin
							rank_nxt[w] = rank_cur[w] + RANK_MRU;
						end
					end
					if (cmd_s1 != CMD_READ) begin
						rdata_c = '0;
					end
				end else begin
					stall_c = penalty_q;
					rdata_c = '0;
				end
			end
			CMD_FILL: begin
				rdata_c = '0;
				if (!found_m && !found_e) begin
					ev_valid_c = 1'b1;
					ev_addr_c  = {ev_tag, set_s1, 3'b000};
				end
				for (int w = 0; w < WAYS; w++) begin
					if (victim_oh[w]) begin
						rank_nxt[w]   = RANK_MRU;
						tag_nxt[w]    = tag_s1;
						row_nxt[w][0] = flo_s1;
						row_nxt[w][1] = fhi_s1;
					end else if (found_m) begin
						if (rank_cur[w] != RANK_INV && rank_cur[w] < hit_rank) begin
							rank_nxt[w] = rank_cur[w] + RANK_MRU;
						end
					end else if (rank_cur[w] != RANK_INV && rank_cur[w] < RANK_MAX) begin
						rank_nxt[w] = rank_cur[w] + RANK_MRU;
					end
				end
			end
			default: begin
				rdata_c = '0;
			end
		endcase

		if (!ev_valid_c) begin
			ev_lo_c = '0;
			ev_hi_c = '0;
		end
	end

	// Block memory: one row per set, read as the access is accepted. A row
	// being written back by stage 1 in the same cycle is forwarded.
	always_ff @(posedge clk) begin
		if (adv) begin
			data_mem[set_s1] <= row_nxt;
		end
		if (accept) begin
			if (adv && set_s1 == req.address[3]) begin
				row_s1 <= row_nxt;
			end else begin
				row_s1 <= data_mem[req.address[3]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q <= '0;
			for (int s = 0; s < SETS; s++) begin
				rank_q[s] <= '0;
				tag_q[s]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				penalty_q <= cfg_wdata;
			end
			if (adv) begin
				rank_q[set_s1] <= rank_nxt;
				tag_q[set_s1]  <= tag_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.command;
			tag_s1   <= req.address[31:4];
			set_s1   <= req.address[3];
			word_s1  <= req.address[2];
			wdata_s1 <= req.write_data;
			flo_s1   <= req.fill_word_lo;
			fhi_s1   <= req.fill_word_hi;
		end
		if (adv) begin
			hit_q      <= hit_c;
			rdata_q    <= rdata_c;
			stall_q    <= stall_c;
			ev_valid_q <= ev_valid_c;
			ev_addr_q  <= ev_addr_c;
			ev_lo_q    <= ev_lo_c;
			ev_hi_q    <= ev_hi_c;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.read_data     = rdata_q;
	assign rsp.stall_cycles  = stall_q;
	assign rsp.evict_valid   = ev_valid_q;
	assign rsp.evict_address = ev_addr_q;
	assign rsp.evict_word_lo = ev_lo_q;
	assign rsp.evict_word_hi = ev_hi_q;

endmodule
`default_nettype wire
